>>> hdl/cache_budget_admission_core_macros.svh
// Assertion macros shared by the admission core.
`ifndef CACHE_BUDGET_ADMISSION_CORE_MACROS_SVH
`define CACHE_BUDGET_ADMISSION_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Check in the same cycle: whenever ante holds, cons holds too.
`define CBA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("admission core check failed");

// Delayed check: whenever ante holds, cons holds at the next edge.
`define CBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("admission core check failed");

`else

`define CBA_ASSERT_IMP(lbl, ante, cons)
`define CBA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> hdl/cba_pkg.sv
// Types and constants shared by the admission core modules.
package cba_pkg;

  localparam int FIELD_W        = 48;
  localparam int CLASSES_DEF    = 8;
  localparam int COUNT_BITS_DEF = 48;
  localparam int CFG_IDX_W      = 3;
  localparam int IN_TDATA_W     = 104;
  localparam int OUT_TDATA_W    = 152;

  typedef enum logic [1:0] {
    MODE_RESERVE = 2'd0,
    MODE_COMMIT  = 2'd1,
    MODE_CANCEL  = 2'd2,
    MODE_RELEASE = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_REFUSED   = 3'd1,
    ST_BAD_CLASS = 3'd2,
    ST_NO_RES    = 3'd3,
    ST_NO_OWN    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CFG_BUDGET_TARGET = 3'd0,
    CFG_FREE_FLOOR    = 3'd1,
    CFG_SHRINK_TARGET = 3'd2,
    CFG_RESIZE_ACTIVE = 3'd3,
    CFG_POLICY_READY  = 3'd4
  } cfg_idx_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_USED,
    S_OVF,
    S_LIM,
    S_FLR1,
    S_FLR2,
    S_FLR3,
    S_REF,
    S_ADD_TP,
    S_ADD_CP,
    S_CHK_P,
    S_SUB_TP,
    S_ADD_CR,
    S_ADD_TR,
    S_CHK_R,
    S_SUB_TR,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    OPA_TOT_RES,
    OPA_TOT_PEND,
    OPA_ACC,
    OPA_LIMIT,
    OPA_FREE,
    OPA_CLS_PEND,
    OPA_CLS_RES,
    OPA_REFUSALS
  } opa_e;

  typedef enum logic [2:0] {
    OPB_TOT_PEND,
    OPB_BYTES,
    OPB_FLOOR,
    OPB_ACC,
    OPB_ONE
  } opb_e;

  // Sequencer to datapath.
  typedef struct packed {
    logic    ready;
    opa_e    opa;
    opb_e    opb;
    logic    sub;
    logic    ld_acc;
    logic    wr_tot_pend;
    logic    wr_cls_pend;
    logic    wr_tot_res;
    logic    wr_cls_res;
    logic    wr_refusals;
    logic    deny_ovf;
    logic    deny_borrow;
    logic    st_ld;
    status_e st_code;
    logic    out_ld;
  } ctrl_t;

  // Datapath to sequencer.
  typedef struct packed {
    logic  in_valid;
    mode_e in_mode;
    logic  in_bad;
    mode_e mode;
    logic  pol;
    logic  borrow;
    logic  deny;
    logic  out_free;
  } stat_t;

endpackage

>>> hdl/cache_budget_admission_core.sv
// Byte-budget admission core: top level with counters, config and output register.
//
// Usage: each request on the s_axis side carries one operation (reserve, commit,
// cancel or release) for one memory class and a byte count. The core answers each
// request with exactly one result on the m_axis side: a status code and the
// resident total, pending total and saturating refusal count after the operation.
// Configuration (targets, free floor, resize and policy flags) must be written through
// cfg_we_i/cfg_idx_i/cfg_data_i only while the core is idle; the core itself does
// not enforce this. Sequencing: s_tready_o stays low from acceptance until the
// request is done. A bad class goes straight to the result; the other modes run
// their checks and counter updates as steps of the sequencer, which runs every
// add, subtract and compare through one shared adder, one step per cycle. The
// result appears on m_tvalid_o in the cycle after the last step when the output
// register is free.
// Reset: all counters, the configuration and the control state clear at once;
// the core is ready in the first cycle after reset is released.
// Stall: the output register holds a finished result while m_tready_i is low; the
// core still accepts the next request, but holds its final step until the
// register is free.
`include "cache_budget_admission_core_macros.svh"

module cache_budget_admission_core #(
  parameter int CLASSES    = cba_pkg::CLASSES_DEF,
  parameter int COUNT_BITS = cba_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // mode[1:0], mem_class[5:2], byte_count[53:6], is_optional[54], phys_free[102:55]
  input  logic [cba_pkg::IN_TDATA_W-1:0]  s_tdata_i,
  input  logic                            s_tvalid_i,
  output logic                            s_tready_o,
  // status[2:0], resident_total[50:3], pending_total[98:51], refusal_count[146:99]
  output logic [cba_pkg::OUT_TDATA_W-1:0] m_tdata_o,
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  input  logic                            cfg_we_i,
  input  logic [cba_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cba_pkg::FIELD_W-1:0]     cfg_data_i
);

  import cba_pkg::*;

  // Working width covers counters and 48-bit fields; two guard bits hold
  // the sum of pending total, byte count and floor without wrapping.
  localparam int WW  = (COUNT_BITS > FIELD_W) ? COUNT_BITS : FIELD_W;
  localparam int UW  = WW + 2;
  localparam int CIW = (CLASSES > 1) ? $clog2(CLASSES) : 1;

  // Configuration registers.
  logic [FIELD_W-1:0] budget_target_q;
  logic [FIELD_W-1:0] free_floor_q;
  logic [FIELD_W-1:0] shrink_target_q;
  logic               resize_active_q;
  logic               policy_ready_q;

  // Accounting state.
  logic [COUNT_BITS-1:0] cls_pend_q [CLASSES];
  logic [COUNT_BITS-1:0] cls_res_q  [CLASSES];
  logic [COUNT_BITS-1:0] tot_pend_q;
  logic [COUNT_BITS-1:0] tot_res_q;
  logic [COUNT_BITS-1:0] refusals_q;

  // Latched request.
  mode_e              mode_q;
  logic [3:0]         cls_q;
  logic [FIELD_W-1:0] bytes_q;
  logic [FIELD_W-1:0] free_q;
  logic               pol_q;

  logic [UW-1:0] acc_q;
  logic          deny_q, deny_d;
  status_e       status_q;

  logic                   out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q;

  ctrl_t ctrl;
  stat_t stat;

  logic          accept;
  logic          in_bad;
  logic [UW-1:0] op_a, op_b, alu_res;
  logic          borrow;
  logic          ovf;
  logic [CIW-1:0] cls_idx;

  assign accept  = s_tvalid_i & s_tready_o;
  assign in_bad  = (5'(s_tdata_i[5:2]) >= 5'(CLASSES));
  assign cls_idx = cls_q[CIW-1:0];

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_target_q <= '0;
      free_floor_q    <= '0;
      shrink_target_q <= '0;
      resize_active_q <= 1'b0;
      policy_ready_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BUDGET_TARGET: budget_target_q <= cfg_data_i;
        CFG_FREE_FLOOR:    free_floor_q    <= cfg_data_i;
        CFG_SHRINK_TARGET: shrink_target_q <= cfg_data_i;
        CFG_RESIZE_ACTIVE: resize_active_q <= cfg_data_i[0];
        CFG_POLICY_READY:  policy_ready_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Capture the request fields on accept.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_e'(s_tdata_i[1:0]);
      cls_q   <= s_tdata_i[5:2];
      bytes_q <= s_tdata_i[53:6];
      pol_q   <= s_tdata_i[54] & policy_ready_q;
      free_q  <= s_tdata_i[102:55];
    end
  end

  // Operand select for the shared unit.
  always_comb begin
    unique case (ctrl.opa)
      OPA_TOT_RES:  op_a = UW'(tot_res_q);
      OPA_TOT_PEND: op_a = UW'(tot_pend_q);
      OPA_ACC:      op_a = acc_q;
      OPA_LIMIT:    op_a = resize_active_q ? UW'(shrink_target_q) : UW'(budget_target_q);
      OPA_FREE:     op_a = UW'(free_q);
      OPA_CLS_PEND: op_a = UW'(cls_pend_q[cls_idx]);
      OPA_CLS_RES:  op_a = UW'(cls_res_q[cls_idx]);
      OPA_REFUSALS: op_a = UW'(refusals_q);
      default:      op_a = acc_q;
    endcase
  end

  always_comb begin
    unique case (ctrl.opb)
      OPB_TOT_PEND: op_b = UW'(tot_pend_q);
      OPB_BYTES:    op_b = UW'(bytes_q);
      OPB_FLOOR:    op_b = UW'(free_floor_q);
      OPB_ACC:      op_b = acc_q;
      OPB_ONE:      op_b = UW'(1);
      default:      op_b = UW'(bytes_q);
    endcase
  end

  cba_alu #(
    .UW(UW)
  ) u_alu (
    .a_i     (op_a),
    .b_i     (op_b),
    .sub_i   (ctrl.sub),
    .res_o   (alu_res),
    .borrow_o(borrow)
  );

  // A sum at or above 2^COUNT_BITS does not fit a counter.
  assign ovf = |alu_res[UW-1:COUNT_BITS];

  // Refusal flag: clear on a new request, set by the overflow or borrow checks.
  always_comb begin
    if (accept) begin
      deny_d = 1'b0;
    end else begin
      deny_d = deny_q | (ctrl.deny_ovf & ovf) | (ctrl.deny_borrow & borrow);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deny_q <= 1'b0;
    end else begin
      deny_q <= deny_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.ld_acc) begin
      acc_q <= alu_res;
    end
    if (ctrl.st_ld) begin
      status_q <= ctrl.st_code;
    end
  end

  // Counter write-back from the shared unit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CLASSES; i++) begin
        cls_pend_q[i] <= '0;
        cls_res_q[i]  <= '0;
      end
      tot_pend_q <= '0;
      tot_res_q  <= '0;
      refusals_q <= '0;
    end else begin
      if (ctrl.wr_cls_pend) begin
        cls_pend_q[cls_idx] <= alu_res[COUNT_BITS-1:0];
      end
      if (ctrl.wr_cls_res) begin
        cls_res_q[cls_idx] <= alu_res[COUNT_BITS-1:0];
      end
      if (ctrl.wr_tot_pend) begin
        tot_pend_q <= alu_res[COUNT_BITS-1:0];
      end
      if (ctrl.wr_tot_res) begin
        tot_res_q <= alu_res[COUNT_BITS-1:0];
      end
      // Saturate: drop the increment once the counter is full.
      if (ctrl.wr_refusals && !ovf) begin
        refusals_q <= alu_res[COUNT_BITS-1:0];
      end
    end
  end

  // Output register: load when empty or being drained this cycle.
  always_comb begin
    if (ctrl.out_ld) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_ld) begin
      out_data_q <= {5'b0,
                     FIELD_W'(refusals_q),
                     FIELD_W'(tot_pend_q),
                     FIELD_W'(tot_res_q),
                     status_q};
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign s_tready_o = ctrl.ready;

  // Status toward the sequencer.
  always_comb begin
    stat.in_valid = s_tvalid_i;
    stat.in_mode  = mode_e'(s_tdata_i[1:0]);
    stat.in_bad   = in_bad;
    stat.mode     = mode_q;
    stat.pol      = pol_q;
    stat.borrow   = borrow;
    stat.deny     = deny_d;
    stat.out_free = ~out_valid_q | m_tready_i;
  end

  cba_seq u_seq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .stat_i(stat),
    .ctrl_o(ctrl)
  );

  // A request is never accepted back to back with the one before it.
  `CBA_ASSERT_NEXT(a_busy_after_accept, accept, !s_tready_o)
  // The refusal count never goes down.
  `CBA_ASSERT_NEXT(a_refusals_monotonic, 1'b1, refusals_q >= $past(refusals_q))
  // A refused reserve never reaches the pending total.
  `CBA_ASSERT_IMP(a_deny_blocks_pending, deny_q, !ctrl.wr_tot_pend)

endmodule

>>> hdl/cba_alu.sv
// Shared add/subtract unit with borrow flag.
module cba_alu #(
  parameter int UW = 50
) (
  input  logic [UW-1:0] a_i,
  input  logic [UW-1:0] b_i,
  input  logic          sub_i,
  output logic [UW-1:0] res_o,
  output logic          borrow_o
);

  logic [UW:0] sum;

  // One adder: subtract as a plus inverted b plus one.
  assign sum = {1'b0, a_i} + {1'b0, b_i ^ {UW{sub_i}}} + (UW+1)'(sub_i);

  assign res_o    = sum[UW-1:0];
  assign borrow_o = sub_i & ~sum[UW];

endmodule

>>> hdl/cba_seq.sv
// Step sequencer that drives the shared unit for one request at a time.
module cba_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cba_pkg::stat_t stat_i,
  output cba_pkg::ctrl_t ctrl_o
);

  import cba_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (stat_i.in_valid) begin
          if (stat_i.in_bad) begin
            state_d = S_DONE;
          end else begin
            unique case (stat_i.in_mode)
              MODE_RESERVE: state_d = S_USED;
              MODE_COMMIT,
              MODE_CANCEL:  state_d = S_CHK_P;
              MODE_RELEASE: state_d = S_CHK_R;
              default:      state_d = S_DONE;
            endcase
          end
        end
      end
      S_USED: state_d = S_OVF;
      S_OVF: begin
        if (stat_i.pol) begin
          state_d = S_LIM;
        end else begin
          state_d = stat_i.deny ? S_REF : S_ADD_TP;
        end
      end
      S_LIM:    state_d = S_FLR1;
      S_FLR1:   state_d = S_FLR2;
      S_FLR2:   state_d = S_FLR3;
      S_FLR3:   state_d = stat_i.deny ? S_REF : S_ADD_TP;
      S_REF:    state_d = S_DONE;
      S_ADD_TP: state_d = S_ADD_CP;
      S_ADD_CP: state_d = S_DONE;
      S_CHK_P:  state_d = stat_i.borrow ? S_DONE : S_SUB_TP;
      S_SUB_TP: state_d = (stat_i.mode == MODE_COMMIT) ? S_ADD_CR : S_DONE;
      S_ADD_CR: state_d = S_ADD_TR;
      S_ADD_TR: state_d = S_DONE;
      S_CHK_R:  state_d = stat_i.borrow ? S_DONE : S_SUB_TR;
      S_SUB_TR: state_d = S_DONE;
      S_DONE:   state_d = stat_i.out_free ? S_IDLE : S_DONE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Outputs per step.
  always_comb begin
    ctrl_o         = '0;
    ctrl_o.opa     = OPA_ACC;
    ctrl_o.opb     = OPB_BYTES;
    ctrl_o.st_code = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        ctrl_o.ready = 1'b1;
        if (stat_i.in_valid) begin
          ctrl_o.st_ld   = 1'b1;
          ctrl_o.st_code = stat_i.in_bad ? ST_BAD_CLASS : ST_OK;
        end
      end
      S_USED: begin
        ctrl_o.opa    = OPA_TOT_RES;
        ctrl_o.opb    = OPB_TOT_PEND;
        ctrl_o.ld_acc = 1'b1;
      end
      S_OVF: begin
        ctrl_o.ld_acc   = 1'b1;
        ctrl_o.deny_ovf = 1'b1;
      end
      S_LIM: begin
        ctrl_o.opa         = OPA_LIMIT;
        ctrl_o.opb         = OPB_ACC;
        ctrl_o.sub         = 1'b1;
        ctrl_o.deny_borrow = 1'b1;
      end
      S_FLR1: begin
        ctrl_o.opa    = OPA_TOT_PEND;
        ctrl_o.ld_acc = 1'b1;
      end
      S_FLR2: begin
        ctrl_o.opb    = OPB_FLOOR;
        ctrl_o.ld_acc = 1'b1;
      end
      S_FLR3: begin
        ctrl_o.opa         = OPA_FREE;
        ctrl_o.opb         = OPB_ACC;
        ctrl_o.sub         = 1'b1;
        ctrl_o.deny_borrow = 1'b1;
      end
      S_REF: begin
        ctrl_o.opa         = OPA_REFUSALS;
        ctrl_o.opb         = OPB_ONE;
        ctrl_o.wr_refusals = 1'b1;
        ctrl_o.st_ld       = 1'b1;
        ctrl_o.st_code     = ST_REFUSED;
      end
      S_ADD_TP: begin
        ctrl_o.opa         = OPA_TOT_PEND;
        ctrl_o.wr_tot_pend = 1'b1;
      end
      S_ADD_CP: begin
        ctrl_o.opa         = OPA_CLS_PEND;
        ctrl_o.wr_cls_pend = 1'b1;
      end
      S_CHK_P: begin
        ctrl_o.opa         = OPA_CLS_PEND;
        ctrl_o.sub         = 1'b1;
        ctrl_o.wr_cls_pend = ~stat_i.borrow;
        ctrl_o.st_ld       = stat_i.borrow;
        ctrl_o.st_code     = ST_NO_RES;
      end
      S_SUB_TP: begin
        ctrl_o.opa         = OPA_TOT_PEND;
        ctrl_o.sub         = 1'b1;
        ctrl_o.wr_tot_pend = 1'b1;
      end
      S_ADD_CR: begin
        ctrl_o.opa        = OPA_CLS_RES;
        ctrl_o.wr_cls_res = 1'b1;
      end
      S_ADD_TR: begin
        ctrl_o.opa        = OPA_TOT_RES;
        ctrl_o.wr_tot_res = 1'b1;
      end
      S_CHK_R: begin
        ctrl_o.opa        = OPA_CLS_RES;
        ctrl_o.sub        = 1'b1;
        ctrl_o.wr_cls_res = ~stat_i.borrow;
        ctrl_o.st_ld      = stat_i.borrow;
        ctrl_o.st_code    = ST_NO_OWN;
      end
      S_SUB_TR: begin
        ctrl_o.opa        = OPA_TOT_RES;
        ctrl_o.sub        = 1'b1;
        ctrl_o.wr_tot_res = 1'b1;
      end
      S_DONE: begin
        ctrl_o.out_ld = stat_i.out_free;
      end
      default: begin
        ctrl_o.ready = 1'b0;
      end
    endcase
  end

endmodule
